/* design/cel_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cel_pkg
// Shared types and constants for the circular event log: operation codes,
// sequencer states, the stored record layout and count saturation.
// ----------------------------------------------------------------------------
package cel_pkg;

    localparam int DEFAULT_LOG_DEPTH = 512;
    localparam logic [7:0] OCC_MAX = 8'd255;
    localparam int REC_COUNT_MAX = 1023;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR,
        ST_CLR,
        ST_QRY,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [31:0] ts;
        logic [31:0] dtc;
        logic [15:0] id;
        logic [15:0] seq;
        logic [7:0]  pri;
        logic [7:0]  typ;
        logic [7:0]  uds;
        logic [7:0]  occ;
    } log_rec_t;

    function automatic logic [9:0] sat_count(input int unsigned c);
        logic [9:0] r;
        if (c > REC_COUNT_MAX)
        begin
            r = 10'(REC_COUNT_MAX);
        end
        else
        begin
            r = 10'(c);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/circular_event_log.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// circular_event_log
// Ring log of event records held in one synchronous memory. Writes stamp a
// sequence number and bump the slot's saturating occurrence count; reads
// return a slot by index; queries walk the log newest first for an id.
//
//   channel | signals                        | direction
//   --------+--------------------------------+----------
//   in      | in_valid/in_ready, op..index   | to block
//   out     | out_valid/out_ready, hit..count| from block
//
// Write: read of the slot's occurrence count, then write back. Query: one
// memory read per slot scanned, newest first, stopping at the first match
// or once every stored record has been scanned.
// Reset and clear only zero the counters; no memory sweep is needed.
// A result waits in the output register; the sequencer holds while it is full.
// ----------------------------------------------------------------------------
module circular_event_log #(
    parameter int LOG_DEPTH = cel_pkg::DEFAULT_LOG_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [15:0] event_id,
    input  wire logic [7:0]  priority_req,
    input  wire logic [7:0]  event_type,
    input  wire logic [31:0] dtc_number,
    input  wire logic [7:0]  uds_status,
    input  wire logic [31:0] timestamp,
    input  wire logic [8:0]  read_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             hit,
    output logic [15:0]      seq_number,
    output logic [31:0]      rec_timestamp,
    output logic [31:0]      rec_dtc,
    output logic [15:0]      rec_event_id,
    output logic [7:0]       rec_priority,
    output logic [7:0]       rec_type,
    output logic [7:0]       rec_uds_status,
    output logic [7:0]       occurrence,
    output logic [9:0]       record_count
);
    import cel_pkg::*;

    localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(LOG_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(LOG_DEPTH);

    log_rec_t mem [LOG_DEPTH];

    state_t          state_reg, state_next;
    logic [CW-1:0]   valid_count_reg, valid_count_next;
    logic [AW-1:0]   write_slot_reg, write_slot_next;
    logic [15:0]     seq_reg, seq_next;
    logic [AW-1:0]   scan_addr_reg, scan_addr_next;
    logic [CW-1:0]   scan_cnt_reg, scan_cnt_next;
    logic            pend_reg, pend_next;
    logic            resp_hit_reg, resp_hit_next;
    logic            out_valid_reg, out_valid_next;
    logic            hit_reg, hit_next;
    log_rec_t        res_reg, res_next;
    logic [9:0]      rc_reg, rc_next;

    logic [15:0]     id_reg;
    logic [7:0]      pri_reg;
    logic [7:0]      typ_reg;
    logic [31:0]     dtc_reg;
    logic [7:0]      uds_reg;
    logic [31:0]     ts_reg;

    log_rec_t        rdata_reg;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;
    log_rec_t        wr_rec;
    logic [7:0]      occ_old;
    logic            out_free;
    logic            in_xfer;
    logic            full;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign full     = (valid_count_reg == FULL_CNT);

    // unwritten slots only occur while not full, at the write slot
    assign occ_old = full ? rdata_reg.occ : 8'd0;

    always_comb
    begin
        wr_rec     = '0;
        wr_rec.ts  = ts_reg;
        wr_rec.dtc = dtc_reg;
        wr_rec.id  = id_reg;
        wr_rec.seq = seq_reg + 16'd1;
        wr_rec.pri = pri_reg;
        wr_rec.typ = typ_reg;
        wr_rec.uds = uds_reg;
        wr_rec.occ = (occ_old < OCC_MAX) ? occ_old + 8'd1 : occ_old;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            valid_count_reg <= '0;
            write_slot_reg  <= '0;
            seq_reg         <= '0;
            scan_addr_reg   <= '0;
            scan_cnt_reg    <= '0;
            pend_reg        <= 1'b0;
            resp_hit_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_count_reg <= valid_count_next;
            write_slot_reg  <= write_slot_next;
            seq_reg         <= seq_next;
            scan_addr_reg   <= scan_addr_next;
            scan_cnt_reg    <= scan_cnt_next;
            pend_reg        <= pend_next;
            resp_hit_reg    <= resp_hit_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        res_reg <= res_next;
        rc_reg  <= rc_next;
        if (in_xfer)
        begin
            id_reg  <= event_id;
            pri_reg <= priority_req;
            typ_reg <= event_type;
            dtc_reg <= dtc_number;
            uds_reg <= uds_status;
            ts_reg  <= timestamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[write_slot_reg] <= wr_rec;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        valid_count_next = valid_count_reg;
        write_slot_next  = write_slot_reg;
        seq_next         = seq_reg;
        scan_addr_next   = scan_addr_reg;
        scan_cnt_next    = scan_cnt_reg;
        pend_next        = pend_reg;
        resp_hit_next    = resp_hit_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        hit_next         = hit_reg;
        res_next         = res_reg;
        rc_next          = rc_reg;
        rd_en            = 1'b0;
        rd_addr          = write_slot_reg;
        mem_we           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op_t'(op))
                        OP_WRITE:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = write_slot_reg;
                            state_next = ST_WR;
                        end
                        OP_CLEAR:
                        begin
                            state_next = ST_CLR;
                        end
                        OP_READ:
                        begin
                            resp_hit_next = 32'(read_index) < 32'(valid_count_reg);
                            rd_en         = resp_hit_next;
                            rd_addr       = AW'(read_index);
                            state_next    = ST_RESP;
                        end
                        OP_QUERY:
                        begin
                            scan_addr_next = (write_slot_reg == '0) ? LAST_SLOT
                                                                    : write_slot_reg - 1'b1;
                            scan_cnt_next  = '0;
                            pend_next      = 1'b0;
                            state_next     = ST_QRY;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_QRY:
            begin
                if (pend_reg && rdata_reg.id == id_reg)
                begin
                    resp_hit_next = 1'b1;
                    state_next    = ST_RESP;
                end
                else if (scan_cnt_reg == valid_count_reg)
                begin
                    resp_hit_next = 1'b0;
                    state_next    = ST_RESP;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_addr_reg;
                    scan_addr_next = (scan_addr_reg == '0) ? LAST_SLOT
                                                           : scan_addr_reg - 1'b1;
                    scan_cnt_next  = scan_cnt_reg + 1'b1;
                    pend_next      = 1'b1;
                end
            end
            ST_WR:
            begin
                if (out_free)
                begin
                    mem_we           = 1'b1;
                    seq_next         = wr_rec.seq;
                    write_slot_next  = (write_slot_reg == LAST_SLOT) ? '0
                                                                    : write_slot_reg + 1'b1;
                    valid_count_next = full ? valid_count_reg : valid_count_reg + 1'b1;
                    out_valid_next   = 1'b1;
                    hit_next         = 1'b1;
                    res_next         = wr_rec;
                    rc_next          = sat_count(32'(valid_count_next));
                    state_next       = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                if (out_free)
                begin
                    valid_count_next = '0;
                    write_slot_next  = '0;
                    seq_next         = '0;
                    out_valid_next   = 1'b1;
                    hit_next         = 1'b1;
                    res_next         = '0;
                    rc_next          = '0;
                    state_next       = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = resp_hit_reg;
                    res_next       = resp_hit_reg ? rdata_reg : '0;
                    rc_next        = sat_count(32'(valid_count_reg));
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign seq_number     = res_reg.seq;
    assign rec_timestamp  = res_reg.ts;
    assign rec_dtc        = res_reg.dtc;
    assign rec_event_id   = res_reg.id;
    assign rec_priority   = res_reg.pri;
    assign rec_type       = res_reg.typ;
    assign rec_uds_status = res_reg.uds;
    assign occurrence     = res_reg.occ;
    assign record_count   = rc_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(valid_count_reg) <= 32'(LOG_DEPTH))
        else $error("valid count above depth");

    a_slot_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> 32'(write_slot_reg) == 32'(valid_count_reg))
        else $error("write slot out of step with fill count");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_QRY |-> 32'(scan_cnt_reg) <= 32'(valid_count_reg))
        else $error("query scanned past valid records");

    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR && out_free) |=> out_valid_reg && hit_reg
                                             && res_reg.seq == seq_reg)
        else $error("write did not present its record");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hit_reg) |-> res_reg == '0)
        else $error("miss carries record data");

endmodule
`default_nettype wire
